// ===== sv/cvcc_pkg.sv =====
// Package with the types and constants shared by the CV/CC duty controller files.
package cvcc_pkg;

  localparam int unsigned NumWidth = 32;
  localparam int unsigned DenWidth = 20;

  localparam logic [2:0] RegVoltGainP = 3'd0;
  localparam logic [2:0] RegVoltGainI = 3'd1;
  localparam logic [2:0] RegCurrGainP = 3'd2;
  localparam logic [2:0] RegCurrGainI = 3'd3;
  localparam logic [2:0] RegDutyFloor = 3'd4;
  localparam logic [2:0] RegDutyCeil  = 3'd5;
  localparam logic [2:0] RegRampStep  = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_PREP,
    S_MVP,
    S_MVI,
    S_MCP,
    S_MCI,
    S_CLAMP,
    S_SEL,
    S_BACK,
    S_OUT
  } cvcc_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } cvcc_div_sts_t;

endpackage

// ===== sv/cvcc_div.sv =====
// Restoring serial divider that produces one quotient bit per cycle.
module cvcc_div import cvcc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumWidth-1:0] num_i,
  input  logic [DenWidth-1:0] den_i,
  output logic [NumWidth-1:0] quo_o,
  output cvcc_div_sts_t       sts_o
);

  logic [NumWidth-1:0] quo_q, quo_d;
  logic [DenWidth-1:0] rem_q, rem_d;
  logic [DenWidth-1:0] den_q;
  logic [5:0]          cnt_q, cnt_d;
  logic                done_q, done_d;
  logic [DenWidth:0]   shifted;
  logic [DenWidth:0]   trial;

  assign shifted = {rem_q, quo_q[NumWidth-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = 6'(NumWidth);
    end else if (cnt_q != '0) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = trial[DenWidth-1:0];
        quo_d = {quo_q[NumWidth-2:0], 1'b1};
      end else begin
        rem_d = shifted[DenWidth-1:0];
        quo_d = {quo_q[NumWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      done_d = (cnt_q == 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quo_o     = quo_q;
  assign sts_o.busy = (cnt_q != '0);
  assign sts_o.done = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) sts_o.done |-> !sts_o.busy)
    else $error("divider reports done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> sts_o.busy)
    else $error("divider did not start");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (sts_o.busy && !start_i) |=> (cnt_q == $past(cnt_q) - 6'd1))
    else $error("divider bit count did not step");

endmodule

// ===== sv/cv_cc_dual_pi_duty_control.sv =====
// Top level of the dual-loop CV/CC PI duty controller with power-derived current cap.
//
// One input beat carries the enable flag, the measured voltage and current and the
// voltage, current and power setpoints; each input beat yields exactly one output beat
// with the duty in timer ticks and the CV/CC mode flag.
// Input is taken only when in_stall_o is low; the block then works on that beat alone.
// A standby beat (enable low) goes from idle straight to the output step. An enabled
// beat is run by the sequencer stepping the single shared 16x17 multiplier through
// four products plus the add, clamp, select and back-calculation steps.
// The next beat can be taken once the output register has loaded and the sequencer
// is back in idle.
// On every CAP_DECIMATION-th enabled beat the serial divider recomputes the current cap,
// one quotient bit per cycle, before the loops run.
// The result sits in an output register; while out_stall_i is high it holds, and the
// sequencer waits in its final step, so no beat is lost or repeated.
// Configuration writes are accepted in every cycle through cfg_valid_i and cfg_ready_o.
// Reset loads the register defaults, clears integrators, ramp and decimation count,
// sets the cap to CURRENT_CAP_MAX and leaves no output beat pending.
module cv_cc_dual_pi_duty_control import cvcc_pkg::*; #(
  parameter int unsigned CAP_DECIMATION  = 20,
  parameter int unsigned CURRENT_CAP_MAX = 5120
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        output_enable_i,
  input  logic [15:0] measured_voltage_i,
  input  logic [15:0] measured_current_i,
  input  logic [15:0] voltage_setpoint_i,
  input  logic [15:0] current_setpoint_i,
  input  logic [17:0] power_setpoint_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] duty_ticks_o,
  output logic        constant_current_mode_o
);

  cvcc_state_e state_q, state_d;

  logic [15:0] gvp_q, gvi_q, gcp_q, gci_q, floor_q, ceil_q, step_q;
  logic [27:0] vint_q, cint_q;
  logic [15:0] rt_q, cap_q, itgt_q;
  logic [4:0]  dec_q;
  logic        mode_q;
  logic [15:0] vm_q, im_q, vset_q, iset_q;
  logic signed [41:0] pv_q, pc_q, dv_q, dc_q, dfin_q;
  logic [15:0] res_duty_q;
  logic        out_valid_q, out_mode_q;
  logic [15:0] out_duty_q;

  logic        in_acc, out_load, div_start;
  logic [4:0]  dec_inc;
  logic        dec_hit;
  logic [NumWidth-1:0] div_num, div_quo;
  logic [DenWidth-1:0] div_den;
  cvcc_div_sts_t div_sts;

  logic [16:0] ramp_sum;
  logic [15:0] ramp_next;
  logic signed [16:0] verr, cerr, mul_b;
  logic [15:0] mul_a;
  logic signed [33:0] prod;
  logic signed [41:0] prod_x, lo, hi, bv, bc, bv_r, bc_r, tick_r;

  function automatic logic signed [41:0] clamp(input logic signed [41:0] x,
                                               input logic signed [41:0] l,
                                               input logic signed [41:0] h);
    logic signed [41:0] r;
    if (x > h) r = h;
    else if (x < l) r = l;
    else r = x;
    return r;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  assign dec_inc   = dec_q + 5'd1;
  assign dec_hit   = (dec_inc >= 5'(CAP_DECIMATION));
  assign div_start = in_acc && output_enable_i && dec_hit;
  assign div_num   = {1'b0, power_setpoint_i, 13'b0} + {3'b0, power_setpoint_i, 11'b0};
  assign div_den   = {1'b0, measured_voltage_i, 3'b0} + {3'b0, measured_voltage_i, 1'b0}
                   + 20'd1024;

  cvcc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (div_quo),
    .sts_o  (div_sts)
  );

  assign ramp_sum  = {1'b0, rt_q} + {1'b0, step_q};
  assign ramp_next = (rt_q < vset_q) ? ((ramp_sum > {1'b0, vset_q}) ? vset_q
                                                                   : ramp_sum[15:0])
                                     : vset_q;

  assign verr = $signed({1'b0, rt_q}) - $signed({1'b0, vm_q});
  assign cerr = $signed({1'b0, itgt_q}) - $signed({1'b0, im_q});

  always_comb begin
    case (state_q)
      S_MVP:   begin mul_a = gvp_q; mul_b = verr; end
      S_MVI:   begin mul_a = gvi_q; mul_b = verr; end
      S_MCP:   begin mul_a = gcp_q; mul_b = cerr; end
      S_MCI:   begin mul_a = gci_q; mul_b = cerr; end
      default: begin mul_a = gvp_q; mul_b = verr; end
    endcase
  end

  assign prod   = $signed({1'b0, mul_a}) * mul_b;
  assign prod_x = {{8{prod[33]}}, prod};
  assign lo     = $signed({8'b0, floor_q, 18'b0});
  assign hi     = $signed({8'b0, ceil_q, 18'b0});
  assign bv     = clamp(dfin_q - pv_q, lo, hi) + 42'sd512;
  assign bc     = clamp(dfin_q - pc_q, lo, hi) + 42'sd512;
  assign bv_r   = bv >>> 10;
  assign bc_r   = bc >>> 10;
  assign tick_r = (dfin_q + 42'sd131072) >>> 18;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (!output_enable_i) state_d = S_OUT;
          else if (dec_hit) state_d = S_DIV;
          else state_d = S_PREP;
        end
      end
      S_DIV:   if (div_sts.done) state_d = S_PREP;
      S_PREP:  state_d = S_MVP;
      S_MVP:   state_d = S_MVI;
      S_MVI:   state_d = S_MCP;
      S_MCP:   state_d = S_MCI;
      S_MCI:   state_d = S_CLAMP;
      S_CLAMP: state_d = S_SEL;
      S_SEL:   state_d = S_BACK;
      S_BACK:  state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      gvp_q       <= 16'd6144;
      gvi_q       <= 16'd3072;
      gcp_q       <= 16'd6144;
      gci_q       <= 16'd3072;
      floor_q     <= 16'd200;
      ceil_q      <= 16'd20000;
      step_q      <= 16'd102;
      vint_q      <= '0;
      cint_q      <= '0;
      rt_q        <= '0;
      cap_q       <= 16'(CURRENT_CAP_MAX);
      dec_q       <= '0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegVoltGainP: gvp_q   <= cfg_data_i;
          RegVoltGainI: gvi_q   <= cfg_data_i;
          RegCurrGainP: gcp_q   <= cfg_data_i;
          RegCurrGainI: gci_q   <= cfg_data_i;
          RegDutyFloor: floor_q <= cfg_data_i;
          RegDutyCeil:  ceil_q  <= cfg_data_i;
          RegRampStep:  step_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        if (!output_enable_i) begin
          vint_q <= '0;
          cint_q <= '0;
          rt_q   <= '0;
        end else begin
          dec_q <= dec_hit ? 5'd0 : dec_inc;
        end
      end
      if (state_q == S_DIV && div_sts.done) begin
        cap_q <= (div_quo > NumWidth'(CURRENT_CAP_MAX)) ? 16'(CURRENT_CAP_MAX)
                                                         : div_quo[15:0];
      end
      if (state_q == S_PREP) rt_q <= ramp_next;
      if (state_q == S_SEL) mode_q <= (dv_q > dc_q);
      if (state_q == S_BACK) begin
        vint_q <= bv_r[27:0];
        cint_q <= bc_r[27:0];
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      vm_q       <= measured_voltage_i;
      im_q       <= measured_current_i;
      vset_q     <= voltage_setpoint_i;
      iset_q     <= current_setpoint_i;
      res_duty_q <= '0;
    end
    case (state_q)
      S_PREP:  itgt_q <= (iset_q < cap_q) ? iset_q : cap_q;
      S_MVP:   pv_q <= prod_x;
      S_MVI:   dv_q <= pv_q + $signed({4'b0, vint_q, 10'b0}) + prod_x;
      S_MCP:   pc_q <= prod_x;
      S_MCI:   dc_q <= pc_q + $signed({4'b0, cint_q, 10'b0}) + prod_x;
      S_CLAMP: begin
        dv_q <= clamp(dv_q, lo, hi);
        dc_q <= clamp(dc_q, lo, hi);
      end
      S_SEL:   dfin_q <= (dv_q <= dc_q) ? dv_q : dc_q;
      S_BACK:  res_duty_q <= tick_r[15:0];
      default: ;
    endcase
    if (out_load) begin
      out_duty_q <= res_duty_q;
      out_mode_q <= mode_q;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign duty_ticks_o            = out_duty_q;
  assign constant_current_mode_o = out_mode_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> state_q != S_IDLE)
    else $error("sequencer stayed idle after taking an input beat");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_DIV) |-> (div_sts.busy || div_sts.done))
    else $error("waiting on a divider that is not running");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_OUT) |-> (vint_q[27:24] == 4'b0 && cint_q[27:24] == 4'b0))
    else $error("integrator exceeds the duty range");

endmodule
